[hdl/assert_macros.svh]
// Assertion helpers for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(lbl, c, r, ante, cons) \
	lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, c, r, ante, cons) \
	lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/scb_pkg.sv]
`timescale 1ns / 1ps
package scb_pkg;

	localparam int BUF_SIZE_DEF = 8192;
	localparam int ADDR_W_DEF = $clog2(BUF_SIZE_DEF);

	localparam int CMD_W = 2;
	localparam int CHAR_W = 8;
	localparam int LINE_W = 14;
	localparam int CFG_W = 8;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

	localparam logic [LINE_W-1:0] LINE_MAX_COUNT = 14'd16383;
	localparam logic [CFG_W-1:0] SCREEN_LINES_RST = 8'd25;

	// Word index of the screen_lines register on the APB port.
	localparam logic REG_SCREEN_LINES = 1'b0;

	typedef struct packed {
		logic we;
		logic re;
	} ram_ctl_t;

endpackage

[hdl/scb_text_ram.sv]
`timescale 1ns / 1ps
module scb_text_ram #(
	parameter int BUF_SIZE = scb_pkg::BUF_SIZE_DEF,
	parameter int AW = $clog2(BUF_SIZE)
) (
	input  logic                        clk,
	input  scb_pkg::ram_ctl_t           ctl,
	input  logic [AW-1:0]               waddr,
	input  logic [scb_pkg::CHAR_W-1:0]  wdata,
	input  logic [AW-1:0]               raddr,
	output logic [scb_pkg::CHAR_W-1:0]  rdata
);

	logic [scb_pkg::CHAR_W-1:0] mem [BUF_SIZE];
	logic [scb_pkg::CHAR_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		// The read word holds between reads so the sequencer can use it later.
		if (ctl.re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

[hdl/scb_apb_regs.sv]
`timescale 1ns / 1ps
module scb_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scb_pkg::APB_AW-1:0]  paddr,
	input  logic [scb_pkg::APB_DW-1:0]  pwdata,
	output logic [scb_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [scb_pkg::CFG_W-1:0]   screen_lines
);

	logic [scb_pkg::CFG_W-1:0] lines_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= scb_pkg::SCREEN_LINES_RST;
		end else if (wr_en && paddr[2] == scb_pkg::REG_SCREEN_LINES) begin
			lines_q <= pwdata[scb_pkg::CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == scb_pkg::REG_SCREEN_LINES) begin
			prdata = {{(scb_pkg::APB_DW-scb_pkg::CFG_W){1'b0}}, lines_q};
		end
	end

	assign screen_lines = lines_q;

endmodule

[hdl/scb_ctrl.sv]
`timescale 1ns / 1ps
module scb_ctrl #(
	parameter int BUF_SIZE = scb_pkg::BUF_SIZE_DEF,
	parameter int AW = $clog2(BUF_SIZE)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [scb_pkg::CFG_W-1:0]   screen_lines,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [scb_pkg::CMD_W-1:0]   command,
	input  logic [scb_pkg::CHAR_W-1:0]  char_byte,
	input  logic                        last_of_write,
	input  logic [AW-1:0]               read_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [scb_pkg::CHAR_W-1:0]  read_data,
	output logic [AW-1:0]               view_start,
	output logic [AW-1:0]               window_start,
	output logic [AW-1:0]               write_pos,
	output scb_pkg::ram_ctl_t           ram_ctl,
	output logic [AW-1:0]               ram_waddr,
	output logic [scb_pkg::CHAR_W-1:0]  ram_wdata,
	output logic [AW-1:0]               ram_raddr,
	input  logic [scb_pkg::CHAR_W-1:0]  ram_rdata
);

	localparam int LW = scb_pkg::LINE_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(BUF_SIZE - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_TRIM0 = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;

	logic [2:0] state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] win_q;
	logic [AW-1:0] view_q;
	logic [LW-1:0] lc_q;
	logic [AW-1:0] p_q;
	logic trim_q;
	logic [scb_pkg::CMD_W-1:0] cmd_q;

	logic out_valid_q;
	logic [scb_pkg::CHAR_W-1:0] rdata_q;
	logic [AW-1:0] view_out_q;
	logic [AW-1:0] win_out_q;
	logic [AW-1:0] wp_out_q;

	logic [scb_pkg::CFG_W-1:0] height;
	logic [LW-1:0] height_w;
	logic [AW-1:0] addr_mod;
	logic [AW-1:0] wp_inc, wp_dec, p_inc, nxt;
	logic hit_nl, scan_done;
	logic [LW-1:0] lc_wr, lc_dec;
	logic out_load;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
		wrap_inc = (x == LAST_IDX) ? '0 : x + AW'(1);
	endfunction

	assign height = (screen_lines == '0) ? scb_pkg::CFG_W'(1) : screen_lines;
	assign height_w = {{(LW-scb_pkg::CFG_W){1'b0}}, height};

	assign addr_mod = ({1'b0, read_address} >= (AW+1)'(BUF_SIZE)) ?
		read_address - AW'(BUF_SIZE) : read_address;

	assign wp_inc = wrap_inc(wp_q);
	assign wp_dec = (wp_q == '0) ? LAST_IDX : wp_q - AW'(1);
	assign p_inc = wrap_inc(p_q);

	// The scan pipelines one byte per cycle: ram_rdata is the byte at p_q.
	assign hit_nl = (ram_rdata == scb_pkg::CH_NEWLINE);
	assign scan_done = hit_nl || (p_q == wp_q);
	assign nxt = hit_nl ? p_inc : p_q;

	assign lc_wr = (char_byte == scb_pkg::CH_NEWLINE && lc_q < scb_pkg::LINE_MAX_COUNT) ?
		lc_q + LW'(1) : lc_q;
	assign lc_dec = lc_q - LW'(1);

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		ram_ctl = '0;
		ram_waddr = wp_q;
		ram_wdata = char_byte;
		ram_raddr = p_inc;
		case (state_q)
			ST_CLEAR: begin
				ram_ctl.we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (command)
						scb_pkg::CMD_WRITE: begin
							ram_ctl.we = (char_byte != scb_pkg::CH_BACKSPACE) &&
								(char_byte != scb_pkg::CH_NUL);
						end
						scb_pkg::CMD_SCROLL: begin
							ram_ctl.re = 1'b1;
							ram_raddr = view_q;
						end
						scb_pkg::CMD_READ: begin
							ram_ctl.re = 1'b1;
							ram_raddr = addr_mod;
						end
						default: ;
					endcase
				end
			end
			ST_TRIM0: begin
				ram_ctl.re = 1'b1;
				ram_raddr = win_q;
			end
			ST_SCAN: begin
				if (!scan_done) begin
					ram_ctl.re = 1'b1;
					ram_raddr = p_inc;
				end else if (trim_q && nxt != win_q && lc_dec >= height_w) begin
					ram_ctl.re = 1'b1;
					ram_raddr = nxt;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			wp_q <= '0;
			win_q <= '0;
			view_q <= '0;
			lc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						case (command)
							scb_pkg::CMD_WRITE: begin
								if (char_byte == scb_pkg::CH_BACKSPACE) begin
									wp_q <= wp_dec;
								end else if (char_byte != scb_pkg::CH_NUL) begin
									wp_q <= wp_inc;
									lc_q <= lc_wr;
								end
								if (last_of_write && char_byte != scb_pkg::CH_BACKSPACE &&
										char_byte != scb_pkg::CH_NUL && lc_wr >= height_w) begin
									state_q <= ST_TRIM0;
								end else if (last_of_write && lc_q >= height_w) begin
									state_q <= ST_TRIM0;
								end else begin
									view_q <= win_q;
									state_q <= ST_FIN;
								end
							end
							scb_pkg::CMD_SCROLL: begin
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_TRIM0: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (!trim_q) begin
							view_q <= (nxt > win_q) ? win_q : nxt;
							state_q <= ST_FIN;
						end else if (nxt == win_q) begin
							// No newline ahead: the window cannot move; the count settles and the view returns to the window.
							lc_q <= height_w - LW'(1);
							view_q <= win_q;
							state_q <= ST_FIN;
						end else begin
							win_q <= nxt;
							lc_q <= lc_dec;
							if (lc_dec < height_w) begin
								view_q <= nxt;
								state_q <= ST_FIN;
							end
						end
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q <= command;
			trim_q <= (command == scb_pkg::CMD_WRITE);
			p_q <= view_q;
		end else if (state_q == ST_TRIM0) begin
			p_q <= win_q;
		end else if (state_q == ST_SCAN) begin
			p_q <= scan_done ? nxt : p_inc;
		end
		if (out_load) begin
			rdata_q <= (cmd_q == scb_pkg::CMD_READ) ? ram_rdata : '0;
			view_out_q <= view_q;
			win_out_q <= win_q;
			wp_out_q <= wp_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = rdata_q;
	assign view_start = view_out_q;
	assign window_start = win_out_q;
	assign write_pos = wp_out_q;

endmodule

[hdl/text_console_scrollback_top.sv]
`timescale 1ns / 1ps
// Write without trimming, read and unused commands: accept, finish state, result register.
// Scroll-down and trimming: the newline scan tests one byte per cycle, then finishes.
// One word is in flight at a time: no word is taken until the last result is loaded.
// The scan rate is set by the single read port of the text memory, one byte a cycle.
// After reset the text memory is cleared, one entry a cycle, all BUF_SIZE entries
// (8192 by default); no word is accepted until then, configuration writes are.
module text_console_scrollback_top #(
	parameter int BUF_SIZE = scb_pkg::BUF_SIZE_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [scb_pkg::APB_AW-1:0]             paddr,
	input  logic [scb_pkg::APB_DW-1:0]             pwdata,
	output logic [scb_pkg::APB_DW-1:0]             prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [scb_pkg::CMD_W-1:0]              command,
	input  logic [scb_pkg::CHAR_W-1:0]             char_byte,
	input  logic                                   last_of_write,
	input  logic [$clog2(BUF_SIZE)-1:0]            read_address,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [scb_pkg::CHAR_W-1:0]             read_data,
	output logic [$clog2(BUF_SIZE)-1:0]            view_start,
	output logic [$clog2(BUF_SIZE)-1:0]            window_start,
	output logic [$clog2(BUF_SIZE)-1:0]            write_pos
);

	localparam int AW = $clog2(BUF_SIZE);

	logic [scb_pkg::CFG_W-1:0] screen_lines;
	scb_pkg::ram_ctl_t ram_ctl;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [scb_pkg::CHAR_W-1:0] ram_wdata;
	logic [scb_pkg::CHAR_W-1:0] ram_rdata;

	scb_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.screen_lines (screen_lines)
	);

	scb_text_ram #(
		.BUF_SIZE (BUF_SIZE),
		.AW       (AW)
	) u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	scb_ctrl #(
		.BUF_SIZE (BUF_SIZE),
		.AW       (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.screen_lines  (screen_lines),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.char_byte     (char_byte),
		.last_of_write (last_of_write),
		.read_address  (read_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.view_start    (view_start),
		.window_start  (window_start),
		.write_pos     (write_pos),
		.ram_ctl       (ram_ctl),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

endmodule

[hdl/scb_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scb_checker #(
	parameter int AW = scb_pkg::ADDR_W_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [scb_pkg::CHAR_W-1:0]  read_data,
	input logic [AW-1:0]               view_start,
	input logic [AW-1:0]               window_start,
	input logic [AW-1:0]               write_pos
);

	// A stalled result word stays offered and unchanged.
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`CHK_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(read_data) && $stable(view_start) && $stable(window_start) && $stable(write_pos))

	// One word at a time: the block is busy right after it takes a word.
	`CHK_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// A new result only appears while the input side is held off.
	`CHK_IMPL(a_result_while_busy, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind text_console_scrollback_top scb_checker #(.AW(AW)) u_scb_checker (.*);
